>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion shorthands, sampled on clk with arst_n low disabling them
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> design/epr_pkg.sv
// ---------------------------------------------------------------------------
// epr_pkg
// shared types and constants of the emulation prevention removal packer
// ---------------------------------------------------------------------------
package epr_pkg;

	typedef enum logic [1:0] {
		KIND_WORD    = 2'd0,
		KIND_OFFSET  = 2'd1,
		KIND_SUMMARY = 2'd2
	} kind_t;

	localparam logic [7:0] PREVENT_BYTE = 8'h03;
	localparam logic [7:0] BYTE_MASK    = 8'hff;
	localparam int         WORD_BYTES   = 4;
	localparam logic [1:0] ZERO_RUN_MAX = 2'd3;
	localparam logic [1:0] ZERO_RUN_ESC = 2'd2;
	localparam logic [1:0] LANE_LAST    = 2'd3;

	// results one byte can cause, and the width of their count
	localparam int PUSH_MAX   = 3;
	localparam int PUSH_CNT_W = 2;

	// result bits that do not scale with INDEX_BITS
	localparam int RES_FIXED_W = 37;

endpackage

>>> design/epr_if.sv
// ---------------------------------------------------------------------------
// epr_if
// handshake channels: raw byte input, result output, register write
// ---------------------------------------------------------------------------
interface epr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface epr_result_if #(parameter int INDEX_BITS = 24);
	logic                  valid;
	logic                  ready;
	logic [1:0]            kind;
	logic [31:0]           word_data;
	logic [INDEX_BITS-1:0] removed_offset;
	logic [INDEX_BITS:0]   unit_size;
	logic                  too_long;
	logic                  last;

	modport source (
		output valid, output kind, output word_data, output removed_offset,
		output unit_size, output too_long, output last, input ready
	);
	modport sink (
		input valid, input kind, input word_data, input removed_offset,
		input unit_size, input too_long, input last, output ready
	);
endinterface

interface epr_cfg_if;
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> design/epr_resq.sv
// ---------------------------------------------------------------------------
// epr_resq
// result queue: takes up to three words a cycle, gives one per ready cycle
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module epr_resq
	import epr_pkg::*;
#(
	parameter int WIDTH     = 85,
	parameter int DEPTH_LOG = 3
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [PUSH_CNT_W-1:0]          push_cnt,
	input  logic [PUSH_MAX-1:0][WIDTH-1:0] push_data,
	output logic [DEPTH_LOG:0]             room,
	output logic                           rd_valid,
	input  logic                           rd_ready,
	output logic [WIDTH-1:0]               rd_data
);

	localparam int DEPTH = 1 << DEPTH_LOG;

	logic [WIDTH-1:0]     mem_q [DEPTH];
	logic [DEPTH_LOG-1:0] head_q;
	logic [DEPTH_LOG-1:0] tail_q;
	logic [DEPTH_LOG:0]   level_q;
	logic                 pop;

	assign rd_valid = level_q != '0;
	assign rd_data  = mem_q[head_q];
	assign pop      = rd_valid && rd_ready;
	assign room     = (DEPTH_LOG + 1)'(DEPTH) - level_q;

	always_ff @(posedge clk) begin
		for (int i = 0; i < PUSH_MAX; i++) begin
			if (PUSH_CNT_W'(i) < push_cnt) begin
				mem_q[tail_q + DEPTH_LOG'(i)] <= push_data[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			level_q <= '0;
		end else begin
			tail_q  <= tail_q + DEPTH_LOG'(push_cnt);
			head_q  <= head_q + DEPTH_LOG'(pop);
			level_q <= level_q + (DEPTH_LOG + 1)'(push_cnt) - (DEPTH_LOG + 1)'(pop);
		end
	end

	`ASSERT_CLK(a_resq_no_overflow, (DEPTH_LOG + 2)'(level_q) + (DEPTH_LOG + 2)'(push_cnt) <= (DEPTH_LOG + 2)'(DEPTH), "result queue overflow")
	`ASSERT_NEXT(a_resq_pop_frees, pop && push_cnt == '0, level_q == $past(level_q) - 1'b1, "pop did not free an entry")

endmodule

>>> design/epr_core.sv
// ---------------------------------------------------------------------------
// epr_core
// input register, escape removal, word packing and unit summary
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module epr_core
	import epr_pkg::*;
#(
	parameter int INDEX_BITS = 24,
	parameter int ROOM_BITS  = 4
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	epr_byte_if.sink                                        nal,
	epr_cfg_if.sink                                         cfg,
	input  logic [ROOM_BITS-1:0]                            room,
	output logic [PUSH_CNT_W-1:0]                           push_cnt,
	output logic [PUSH_MAX-1:0][2*INDEX_BITS+RES_FIXED_W-1:0] push_data
);

	typedef struct packed {
		kind_t                 kind;
		logic [31:0]           word_data;
		logic [INDEX_BITS-1:0] removed_offset;
		logic [INDEX_BITS:0]   unit_size;
		logic                  too_long;
		logic                  last;
	} res_t;

	logic                  valid_s1;
	logic [7:0]            data_s1;
	logic                  last_s1;

	logic                  record_q;
	logic [1:0]            zero_run_q;
	logic [INDEX_BITS-1:0] byte_index_q;
	logic                  index_full_q;
	logic                  overflow_q;
	logic [1:0]            lane_q;
	logic [23:0]           accum_q;
	logic [INDEX_BITS:0]   kept_q;

	logic [1:0]            zero_run_n;
	logic [INDEX_BITS-1:0] byte_index_n;
	logic                  index_full_n;
	logic                  overflow_n;
	logic [1:0]            lane_n;
	logic [23:0]           accum_n;
	logic [INDEX_BITS:0]   kept_n;

	res_t                  slot [PUSH_MAX];
	logic [PUSH_CNT_W-1:0] cnt;

	assign cfg.ready = 1'b1;
	assign nal.ready = valid_s1 ? (room >= ROOM_BITS'(2 * PUSH_MAX))
	                            : (room >= ROOM_BITS'(PUSH_MAX));

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= nal.valid && nal.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (nal.valid && nal.ready) begin
			data_s1 <= nal.data_byte & BYTE_MASK;
			last_s1 <= nal.last_byte;
		end
	end

	always_comb begin
		logic                  drop;
		logic                  word_done;
		logic [31:0]           full_word;
		logic [31:0]           pad_word;
		logic [INDEX_BITS+1:0] size_sum;
		res_t                  r_main;
		res_t                  r_pad;
		res_t                  r_sum;

		drop = data_s1 == PREVENT_BYTE && zero_run_q >= ZERO_RUN_ESC;

		overflow_n   = overflow_q | index_full_q;
		index_full_n = index_full_q;
		byte_index_n = byte_index_q;
		if (byte_index_q == '1) begin
			index_full_n = 1'b1;
		end else begin
			byte_index_n = byte_index_q + 1'b1;
		end

		kept_n = kept_q;
		if (!drop && !kept_q[INDEX_BITS]) begin
			kept_n = kept_q + 1'b1;
		end

		full_word = {accum_q, data_s1};
		word_done = 1'b0;
		lane_n    = lane_q;
		accum_n   = accum_q;
		if (!drop) begin
			if (lane_q == LANE_LAST) begin
				word_done = 1'b1;
				lane_n    = 2'd0;
				accum_n   = '0;
			end else begin
				accum_n = {accum_q[15:0], data_s1};
				lane_n  = lane_q + 2'd1;
			end
		end

		if (data_s1 == 8'h00) begin
			zero_run_n = (zero_run_q == ZERO_RUN_MAX) ? zero_run_q : zero_run_q + 2'd1;
		end else begin
			zero_run_n = 2'd0;
		end

		r_main                = '0;
		r_main.kind           = drop ? KIND_OFFSET : KIND_WORD;
		r_main.word_data      = drop ? 32'h0 : full_word;
		r_main.removed_offset = drop ? byte_index_q : '0;
		r_main.last           = !last_s1;

		case (lane_n)
			2'd1: pad_word = {accum_n[7:0], 24'h0};
			2'd2: pad_word = {accum_n[15:0], 16'h0};
			2'd3: pad_word = {accum_n, 8'h0};
			default: pad_word = 32'h0;
		endcase
		r_pad           = '0;
		r_pad.kind      = KIND_WORD;
		r_pad.word_data = pad_word;

		size_sum        = {1'b0, kept_n} + (INDEX_BITS + 2)'(WORD_BYTES - 1);
		r_sum           = '0;
		r_sum.kind      = KIND_SUMMARY;
		r_sum.unit_size = size_sum[INDEX_BITS:0] & ~(INDEX_BITS + 1)'(WORD_BYTES - 1);
		r_sum.too_long  = overflow_n;
		r_sum.last      = 1'b1;

		for (int i = 0; i < PUSH_MAX; i++) begin
			slot[i] = '0;
		end
		cnt = '0;
		if ((drop && record_q) || word_done) begin
			slot[cnt] = r_main;
			cnt = cnt + 1'b1;
		end
		if (last_s1 && lane_n != 2'd0) begin
			slot[cnt] = r_pad;
			cnt = cnt + 1'b1;
		end
		if (last_s1) begin
			slot[cnt] = r_sum;
			cnt = cnt + 1'b1;
		end
		if (!valid_s1) begin
			cnt = '0;
		end

		// end of unit starts the next one from scratch
		if (last_s1) begin
			zero_run_n   = '0;
			byte_index_n = '0;
			index_full_n = 1'b0;
			overflow_n   = 1'b0;
			lane_n       = '0;
			accum_n      = '0;
			kept_n       = '0;
		end
	end

	assign push_cnt = cnt;
	for (genvar g = 0; g < PUSH_MAX; g++) begin : g_push
		assign push_data[g] = slot[g];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_q <= 1'b1;
		end else if (cfg.valid) begin
			record_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_run_q   <= '0;
			byte_index_q <= '0;
			index_full_q <= 1'b0;
			overflow_q   <= 1'b0;
			lane_q       <= '0;
			accum_q      <= '0;
			kept_q       <= '0;
		end else if (valid_s1) begin
			zero_run_q   <= zero_run_n;
			byte_index_q <= byte_index_n;
			index_full_q <= index_full_n;
			overflow_q   <= overflow_n;
			lane_q       <= lane_n;
			accum_q      <= accum_n;
			kept_q       <= kept_n;
		end
	end

	`ASSERT_NEXT(a_core_last_pushes, nal.valid && nal.ready && nal.last_byte, push_cnt != '0, "final byte gave no result")
	`ASSERT_NEXT(a_core_unit_clear, valid_s1 && last_s1, lane_q == 2'd0 && kept_q == '0, "unit state not cleared")
	`ASSERT_IMPLY(a_core_kept_sat, kept_q[INDEX_BITS], kept_q[INDEX_BITS-1:0] == '0, "kept count past limit")

endmodule

>>> design/emulation_prevention_removal_packer.sv
// each taken byte is registered at the input, then written to the result queue
// throughput: one byte per cycle while the queue has room; a final byte adds
// up to two more results, drained one per cycle while result.ready is high
// input stalls only while the queue lacks room for new and held bytes' results
// reset clears unit state and queue, and sets offset recording on
// ---------------------------------------------------------------------------
// emulation_prevention_removal_packer
// drops escape bytes from a unit and packs kept bytes into 32-bit words
// ---------------------------------------------------------------------------
module emulation_prevention_removal_packer
	import epr_pkg::*;
#(
	parameter int INDEX_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	epr_byte_if.sink    nal,
	epr_result_if.source result,
	epr_cfg_if.sink     cfg
);

	localparam int RESQ_DEPTH_LOG = 3;
	localparam int RES_W          = 2 * INDEX_BITS + RES_FIXED_W;
	localparam int KIND_LSB       = RES_W - 2;
	localparam int WORD_LSB       = KIND_LSB - 32;
	localparam int OFF_LSB        = WORD_LSB - INDEX_BITS;
	localparam int SIZE_LSB       = OFF_LSB - INDEX_BITS - 1;

	logic [PUSH_CNT_W-1:0]          push_cnt;
	logic [PUSH_MAX-1:0][RES_W-1:0] push_data;
	logic [RESQ_DEPTH_LOG:0]        room;
	logic [RES_W-1:0]               rd_data;

	epr_core #(
		.INDEX_BITS (INDEX_BITS),
		.ROOM_BITS  (RESQ_DEPTH_LOG + 1)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.nal       (nal),
		.cfg       (cfg),
		.room      (room),
		.push_cnt  (push_cnt),
		.push_data (push_data)
	);

	epr_resq #(
		.WIDTH     (RES_W),
		.DEPTH_LOG (RESQ_DEPTH_LOG)
	) u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.push_data (push_data),
		.room      (room),
		.rd_valid  (result.valid),
		.rd_ready  (result.ready),
		.rd_data   (rd_data)
	);

	assign result.kind           = rd_data[RES_W-1:KIND_LSB];
	assign result.word_data      = rd_data[KIND_LSB-1:WORD_LSB];
	assign result.removed_offset = rd_data[WORD_LSB-1:OFF_LSB];
	assign result.unit_size      = rd_data[OFF_LSB-1:SIZE_LSB];
	assign result.too_long       = rd_data[1];
	assign result.last           = rd_data[0];

endmodule
